// ----- hdl/mwgcd_pkg.sv -----
package mwgcd_pkg;

    // stream payload widths, fixed by the field layout
    localparam int FIELD_W    = 64;
    localparam int IN_DATA_W  = 2 * FIELD_W;
    localparam int OUT_DATA_W = FIELD_W;

    // trailing zero count of a digit, 63 when the digit is zero
    function automatic logic [5:0] tz64(input logic [63:0] x);
        logic [5:0] n;
        n = 6'd63;
        for (int i = 63; i >= 0; i--) begin
            if (x[i]) begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

endpackage

// ----- hdl/multiword_binary_gcd.sv -----
// Multiword binary gcd.
// Slave stream: one request per digit pair, tdata = {v_digit, u_digit}, u_digit in
// bits 63:0 and v_digit in bits 127:64, least significant digit pair first; tlast
// marks the final pair and starts the computation. Pairs past DIGITS are dropped,
// pairs never sent count as zero.
// Master stream: DIGITS requests per gcd, gcd digit in tdata (least significant
// first), tlast on the most significant digit, tuser bit 0 = coprime flag.
// The computation runs one shared digit unit (subtract, compare, funnel shift)
// over the operands held in rotating digit registers, so every pass visits the
// DIGITS digits in turn, and each shift pass is preceded by a decision state. One
// subtract step is a compare pass, a subtract pass and one or more shift passes;
// the number of steps depends on the operands and is at most about 2 * DIGITS *
// DIGIT_BITS. Each right or left shift pass moves up to DIGIT_BITS - 1 bits.
// The slave side is ready only while loading. Results leave through an output
// register; a stall on the master side holds the digit unit until the request is
// taken, and loading of the next operands starts after the last gcd digit has
// been handed to the output register.
// Reset (synchronous, active low) clears both operand stores, state and counters.
module multiword_binary_gcd #(
    parameter int DIGITS     = 4,
    parameter int DIGIT_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // u_digit [63:0], v_digit [127:64]
    input  logic [mwgcd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // final_digit
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // gcd_digit [63:0]
    output logic [mwgcd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // result_last
    output logic                                o_m_axis_tlast,
    // coprime [0]
    output logic                                o_m_axis_tuser
);
    import mwgcd_pkg::*;

    localparam int DB  = DIGIT_BITS;
    localparam int CW  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int LW  = $clog2(DIGITS + 1);
    localparam int TW  = $clog2(DIGITS * DIGIT_BITS);
    localparam int SW  = $clog2(DIGIT_BITS);
    localparam int NXT = (DIGITS > 1) ? 1 : 0;

    typedef enum logic [3:0] {
        S_LOAD,
        S_ZSCAN,
        S_TWOS,
        S_ODD,
        S_SHR,
        S_CMP,
        S_SUB,
        S_SHL_CHK,
        S_SHL,
        S_ONE,
        S_EMIT
    } t_state;

    t_state          r_state;
    logic [DB-1:0]   r_u [DIGITS];
    logic [DB-1:0]   r_v [DIGITS];
    logic [LW-1:0]   r_lpos;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_epos;
    logic [TW-1:0]   r_twos;
    logic [SW-1:0]   r_amt_u;
    logic [SW-1:0]   r_amt_v;
    logic            r_in_twos;
    logic            r_u_big;
    logic            r_gsel;
    logic            r_cop;
    logic            r_bor;
    logic [DB-1:0]   r_cu;
    logic            r_uz, r_vz, r_uone, r_eq, r_gt;
    logic            r_ovalid;
    logic [DB-1:0]   r_odata;
    logic            r_olast;
    logic            r_ouser;

    logic [DB-1:0]   du, dv, du_n, dv_n;
    logic            sweep_st, sweep_last;
    logic [DB-1:0]   n_ud, n_vd;
    logic            n_bor;
    logic            n_uz, n_vz, n_uone, n_eq, n_gt;
    logic [2*DB-1:0] shr_u, shr_v, shl_u;
    logic [DB:0]     diff;
    logic [5:0]      tz_uv, tz_u, tz_v;
    logic [SW-1:0]   amt_uv, amt_u, amt_v, amt_shl;
    logic            out_free;

    assign du         = r_u[0];
    assign dv         = r_v[0];
    assign sweep_last = (r_cnt == CW'(DIGITS - 1));
    assign du_n       = sweep_last ? '0 : r_u[NXT];
    assign dv_n       = sweep_last ? '0 : r_v[NXT];
    assign sweep_st   = r_state inside {S_ZSCAN, S_SHR, S_CMP, S_SUB, S_SHL, S_ONE};

    // funnel shifts over the current digit and its neighbor
    assign shr_u = {du_n, du} >> r_amt_u;
    assign shr_v = {dv_n, dv} >> r_amt_v;
    assign shl_u = {du, r_cu} << r_amt_u;
    assign diff  = r_u_big ? ({1'b0, du} - {1'b0, dv} - {{DB{1'b0}}, r_bor})
                           : ({1'b0, dv} - {1'b0, du} - {{DB{1'b0}}, r_bor});

    // shift amounts, capped at one digit less one bit
    assign tz_uv   = tz64(64'(du | dv));
    assign tz_u    = tz64(64'(du));
    assign tz_v    = tz64(64'(dv));
    assign amt_uv  = (tz_uv > 6'(DB - 1)) ? SW'(DB - 1) : tz_uv[SW-1:0];
    assign amt_u   = (tz_u > 6'(DB - 1)) ? SW'(DB - 1) : tz_u[SW-1:0];
    assign amt_v   = (tz_v > 6'(DB - 1)) ? SW'(DB - 1) : tz_v[SW-1:0];
    assign amt_shl = (r_twos > TW'(DB - 1)) ? SW'(DB - 1) : r_twos[SW-1:0];

    always_comb begin
        n_ud  = du;
        n_vd  = dv;
        n_bor = 1'b0;
        case (r_state)
            S_SHR: begin
                n_ud = shr_u[DB-1:0];
                n_vd = shr_v[DB-1:0];
            end
            S_SHL: begin
                n_ud = shl_u[2*DB-1:DB];
            end
            S_SUB: begin
                n_bor = diff[DB];
                if (r_u_big) begin
                    n_ud = diff[DB-1:0];
                end else begin
                    n_vd = diff[DB-1:0];
                end
            end
            default: begin
                n_ud = du;
                n_vd = dv;
            end
        endcase
        n_uz   = r_uz & (du == '0);
        n_vz   = r_vz & (dv == '0);
        n_uone = r_uone & (du == ((r_cnt == '0) ? DB'(1) : DB'(0)));
        n_eq   = r_eq & (du == dv);
        n_gt   = (du != dv) ? (du > dv) : r_gt;
    end

    assign out_free = !r_ovalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_lpos   <= '0;
            r_cnt    <= '0;
            r_epos   <= '0;
            r_twos   <= '0;
            r_ovalid <= 1'b0;
            r_bor    <= 1'b0;
            r_cu     <= '0;
            r_uz     <= 1'b1;
            r_vz     <= 1'b1;
            r_uone   <= 1'b1;
            r_eq     <= 1'b1;
            r_gt     <= 1'b0;
            for (int i = 0; i < DIGITS; i++) begin
                r_u[i] <= '0;
                r_v[i] <= '0;
            end
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            // digit unit bookkeeping over one pass
            if (sweep_st) begin
                for (int i = 0; i < DIGITS - 1; i++) begin
                    r_u[i] <= r_u[i + 1];
                    r_v[i] <= r_v[i + 1];
                end
                r_u[DIGITS - 1] <= n_ud;
                r_v[DIGITS - 1] <= n_vd;
            end
            if (sweep_st && !sweep_last) begin
                r_cnt  <= r_cnt + CW'(1);
                r_bor  <= n_bor;
                r_cu   <= du;
                r_uz   <= n_uz;
                r_vz   <= n_vz;
                r_uone <= n_uone;
                r_eq   <= n_eq;
                r_gt   <= n_gt;
            end else begin
                r_cnt  <= '0;
                r_bor  <= 1'b0;
                r_cu   <= '0;
                r_uz   <= 1'b1;
                r_vz   <= 1'b1;
                r_uone <= 1'b1;
                r_eq   <= 1'b1;
                r_gt   <= 1'b0;
            end

            case (r_state)
                S_LOAD: begin
                    if (i_s_axis_tvalid) begin
                        if (r_lpos < LW'(DIGITS)) begin
                            r_u[r_lpos[CW-1:0]] <= i_s_axis_tdata[DB-1:0];
                            r_v[r_lpos[CW-1:0]] <= i_s_axis_tdata[FIELD_W+DB-1:FIELD_W];
                            r_lpos <= r_lpos + LW'(1);
                        end
                        if (i_s_axis_tlast) begin
                            r_state <= S_ZSCAN;
                        end
                    end
                end
                S_ZSCAN: begin
                    if (sweep_last) begin
                        r_epos <= '0;
                        r_twos <= '0;
                        if (n_uz) begin
                            r_gsel  <= 1'b1;
                            r_cop   <= n_vz;
                            r_state <= S_EMIT;
                        end else if (n_vz) begin
                            r_gsel  <= 1'b0;
                            r_cop   <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_TWOS;
                        end
                    end
                end
                S_TWOS: begin
                    if (amt_uv == '0) begin
                        r_state <= S_ODD;
                    end else begin
                        r_amt_u   <= amt_uv;
                        r_amt_v   <= amt_uv;
                        r_twos    <= r_twos + TW'(amt_uv);
                        r_in_twos <= 1'b1;
                        r_state   <= S_SHR;
                    end
                end
                S_ODD: begin
                    if (amt_u == '0 && amt_v == '0) begin
                        r_state <= S_CMP;
                    end else begin
                        r_amt_u   <= amt_u;
                        r_amt_v   <= amt_v;
                        r_in_twos <= 1'b0;
                        r_state   <= S_SHR;
                    end
                end
                S_SHR: begin
                    if (sweep_last) begin
                        r_state <= r_in_twos ? S_TWOS : S_ODD;
                    end
                end
                S_CMP: begin
                    if (sweep_last) begin
                        if (n_eq) begin
                            r_gsel  <= 1'b0;
                            r_state <= S_SHL_CHK;
                        end else begin
                            r_u_big <= n_gt;
                            r_state <= S_SUB;
                        end
                    end
                end
                S_SUB: begin
                    if (sweep_last) begin
                        r_state <= S_ODD;
                    end
                end
                S_SHL_CHK: begin
                    // put the shared power of two back
                    if (r_twos == '0) begin
                        r_state <= S_ONE;
                    end else begin
                        r_amt_u <= amt_shl;
                        r_twos  <= r_twos - TW'(amt_shl);
                        r_state <= S_SHL;
                    end
                end
                S_SHL: begin
                    if (sweep_last) begin
                        r_state <= S_SHL_CHK;
                    end
                end
                S_ONE: begin
                    if (sweep_last) begin
                        r_cop   <= n_uone;
                        r_epos  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_gsel ? dv : du;
                        r_olast  <= (r_epos == CW'(DIGITS - 1));
                        r_ouser  <= r_cop;
                        r_epos   <= r_epos + CW'(1);
                        for (int i = 0; i < DIGITS - 1; i++) begin
                            r_u[i] <= r_u[i + 1];
                            r_v[i] <= r_v[i + 1];
                        end
                        r_u[DIGITS - 1] <= du;
                        r_v[DIGITS - 1] <= dv;
                        if (r_epos == CW'(DIGITS - 1)) begin
                            // operand stores start empty for the next gcd
                            for (int i = 0; i < DIGITS; i++) begin
                                r_u[i] <= '0;
                                r_v[i] <= '0;
                            end
                            r_lpos  <= '0;
                            r_twos  <= '0;
                            r_epos  <= '0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_odata);
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_ouser;

    a_lpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lpos <= LW'(DIGITS))
        else $error("load position past operand length");

    a_sub_no_borrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB && sweep_last) |-> !diff[DB])
        else $error("subtract pass ended with a borrow");

    a_cmp_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_cnt == '0) |-> (du[0] && dv[0]))
        else $error("compare pass started on an even operand");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_ovalid && !i_m_axis_tready) |=> $stable(r_epos))
        else $error("gcd digit advanced while output stalled");

endmodule

// ----- dv/tb_multiword_binary_gcd.sv -----
`timescale 1ns / 100ps

module tb_multiword_binary_gcd;

    import mwgcd_pkg::*;

    localparam int DIGITS       = 4;
    localparam int DIGIT_W      = FIELD_W;
    localparam int OP_W         = DIGITS * DIGIT_W;
    localparam int IDLE_PCT     = 38;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_PAIRS = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [OP_W-1:0]    operand_t;

    typedef struct packed {
        digit_t digit;
        logic   last;
        logic   coprime;
    } gcd_word_t;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  s_tvalid         = 1'b0;
    logic                  o_s_axis_tready;
    // u_digit [63:0], v_digit [127:64]
    logic [IN_DATA_W-1:0]  s_tdata          = '0;
    // final_digit
    logic                  s_tlast          = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  m_tready         = 1'b0;
    // gcd_digit [63:0]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // result_last
    logic                  o_m_axis_tlast;
    // coprime [0]
    logic                  o_m_axis_tuser;

    // shared with the receiver, all written with nonblocking assignments
    logic idle_en      = 1'b1;
    int   hold_req_seq = 0;
    int   hold_req_len = 0;
    int   hold_ack_seq = 0;
    int   hold_left    = 0;

    // operand stores of the predictor
    digit_t u_store [DIGITS];
    digit_t v_store [DIGITS];
    int     load_pos = 0;

    gcd_word_t expected_gcd_q [$];

    int err_cnt       = 0;
    int pairs_sent    = 0;
    int random_pairs  = 0;
    int gcd_count     = 0;
    int words_checked = 0;

    always #5 i_clk = ~i_clk;

    multiword_binary_gcd #(
        .DIGITS     (DIGITS),
        .DIGIT_BITS (DIGIT_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    function automatic void stein_gcd(input operand_t a_in, input operand_t b_in,
                                      output operand_t g, output logic cop);
        operand_t a;
        operand_t b;
        int       twos;
        a = a_in;
        b = b_in;
        // a zero operand passes the other one through, flag only when both are zero
        if (a == '0) begin
            g   = b;
            cop = (b == '0);
            return;
        end
        if (b == '0) begin
            g   = a;
            cop = 1'b0;
            return;
        end
        twos = 0;
        while (!(a[0] | b[0])) begin
            a = a >> 1;
            b = b >> 1;
            twos++;
        end
        while (!a[0]) a = a >> 1;
        while (!b[0]) b = b >> 1;
        while (a != b) begin
            if (a > b) begin
                a = a - b;
                while (!a[0]) a = a >> 1;
            end else begin
                b = b - a;
                while (!b[0]) b = b >> 1;
            end
        end
        g   = a << twos;
        cop = (g == operand_t'(1));
    endfunction

    function automatic void predict_pair(input digit_t u, input digit_t v, input logic fin);
        operand_t u_op;
        operand_t v_op;
        operand_t g;
        logic     cop;
        // pairs past the top digit are dropped
        if (load_pos < DIGITS) begin
            u_store[load_pos] = u;
            v_store[load_pos] = v;
            load_pos++;
        end
        if (!fin) return;
        for (int i = 0; i < DIGITS; i++) begin
            u_op[i*DIGIT_W +: DIGIT_W] = (i < load_pos) ? u_store[i] : '0;
            v_op[i*DIGIT_W +: DIGIT_W] = (i < load_pos) ? v_store[i] : '0;
        end
        stein_gcd(u_op, v_op, g, cop);
        for (int i = 0; i < DIGITS; i++) begin
            expected_gcd_q.push_back(
                gcd_word_t'{g[i*DIGIT_W +: DIGIT_W], i == DIGITS - 1, cop});
        end
        load_pos = 0;
        gcd_count++;
    endfunction

    function automatic digit_t rand_digit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return digit_t'(1) << $urandom_range(0, DIGIT_W - 1);
            3:       return digit_t'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // w random bits in the low end
    function automatic operand_t rand_wide(input int w);
        operand_t r;
        for (int i = 0; i < OP_W / 32; i++) r[i*32 +: 32] = $urandom;
        return (w <= 0) ? operand_t'(0) : (r >> (OP_W - w));
    endfunction

    task automatic send_pair(input digit_t u, input digit_t v, input logic fin);
        if (idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, u};
        s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_pair(u, v, fin);
        pairs_sent++;
    endtask

    // n digit pairs, the last one final; pairs past the top digit carry noise
    task automatic send_operands(input operand_t u_op, input operand_t v_op, input int n);
        digit_t u;
        digit_t v;
        for (int i = 0; i < n; i++) begin
            u = (i < DIGITS) ? u_op[i*DIGIT_W +: DIGIT_W] : digit_t'({$urandom, $urandom});
            v = (i < DIGITS) ? v_op[i*DIGIT_W +: DIGIT_W] : digit_t'({$urandom, $urandom});
            send_pair(u, v, i == n - 1);
        end
    endtask

    task automatic send_random_gcd();
        int       n;
        int       used;
        int       bits;
        int       kind;
        int       gw;
        int       sh;
        operand_t u_op;
        operand_t v_op;
        operand_t g_op;
        n = ($urandom_range(99) < 10) ? $urandom_range(DIGITS + 1, DIGITS + 2)
                                      : $urandom_range(1, DIGITS);
        used = (n > DIGITS) ? DIGITS : n;
        bits = used * DIGIT_W;
        kind = $urandom_range(0, 9);
        u_op = '0;
        v_op = '0;
        if (kind < 4) begin
            // common factor with a shared power of two, products fit the sent digits
            gw   = $urandom_range(1, bits / 2);
            sh   = $urandom_range(0, bits / 4);
            g_op = rand_wide(gw) << sh;
            u_op = g_op * rand_wide(bits - gw - sh);
            v_op = g_op * rand_wide(bits - gw - sh);
        end else begin
            for (int i = 0; i < used; i++) begin
                if (kind != 8) u_op[i*DIGIT_W +: DIGIT_W] = rand_digit();
                if (kind != 9) v_op[i*DIGIT_W +: DIGIT_W] = rand_digit();
            end
        end
        send_operands(u_op, v_op, n);
        random_pairs += n;
    endtask

    task automatic wait_for_gcds();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_gcd_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_gcd_word();
        gcd_word_t want;
        if (expected_gcd_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
                $display("unexpected gcd digit %h last %b coprime %b at %0t",
                         o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser, $realtime);
            return;
        end
        want = expected_gcd_q.pop_front();
        words_checked++;
        if (o_m_axis_tdata !== want.digit || o_m_axis_tlast !== want.last ||
            o_m_axis_tuser !== want.coprime) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
                $display({"gcd mismatch at %0t: expected %h last %b coprime %b, ",
                          "got %h last %b coprime %b"},
                         $realtime, want.digit, want.last, want.coprime,
                         o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
        end
    endtask

    // result side: checks each request and drives tready, long hold-offs on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) check_gcd_word();
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_req_seq != hold_ack_seq) begin
            hold_ack_seq <= hold_req_seq;
            hold_left    <= hold_req_len;
            m_tready     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic test_zero_operands();
        send_pair('0, '0, 1'b1);
        send_pair('0, digit_t'(1), 1'b1);
        send_pair(digit_t'(1), '0, 1'b1);
        send_pair(digit_t'(1), digit_t'(1), 1'b1);
    endtask

    task automatic test_extreme_digits();
        send_operands('1, '1, DIGITS);
        // all ones against two is coprime
        send_operands('1, operand_t'(2), DIGITS);
    endtask

    task automatic test_shared_twos();
        send_operands(operand_t'(3) << 200, operand_t'(9) << 130, DIGITS);
    endtask

    task automatic test_digit_overflow();
        send_operands(rand_wide(OP_W), rand_wide(OP_W), DIGITS + 2);
    endtask

    task automatic test_output_stall();
        hold_req_len <= HOLD_CYCLES;
        hold_req_seq <= hold_req_seq + 1;
        repeat (3) send_random_gcd();
        wait_for_gcds();
    endtask

    task automatic test_unbroken_flow();
        idle_en <= 1'b0;
        repeat (12) send_random_gcd();
        idle_en <= 1'b1;
    endtask

    task automatic test_random_gcds();
        while (random_pairs < RANDOM_PAIRS) send_random_gcd();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_operands();
        test_extreme_digits();
        test_shared_twos();
        test_digit_overflow();
        test_output_stall();
        test_unbroken_flow();
        test_random_gcds();
        wait_for_gcds();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_gcd_q.size() != 0) begin
            err_cnt += expected_gcd_q.size();
            $display("%0d gcd digits never arrived", expected_gcd_q.size());
        end
        $display("sent %0d digit pairs (%0d random) forming %0d gcd computations",
                 pairs_sent, random_pairs, gcd_count);
        $display("checked %0d gcd digits, %0d errors", words_checked, err_cnt);
        if (err_cnt == 0) begin
            $display("** multiword_binary_gcd: PASSED **");
        end else begin
            $display("** multiword_binary_gcd: FAILED **");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("timeout with %0d gcd digits outstanding", expected_gcd_q.size());
        $display("** multiword_binary_gcd: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mwgcd_pkg.sv
hdl/multiword_binary_gcd.sv
dv/tb_multiword_binary_gcd.sv
